// File: rtl/core/swrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swrr_pkg;

    // Pool size and derived widths
    localparam int NUM_WORKERS = 16;
    localparam int IDX_W       = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int CNT_W       = $clog2(NUM_WORKERS + 1);
    localparam int WEIGHT_W    = 16;
    localparam int CW_W        = 40;
    // total of all eligible weights in one pick
    localparam int TOT_W       = WEIGHT_W + CNT_W;

    localparam logic signed [CW_W-1:0] CW_MAX = {1'b0, {(CW_W-1){1'b1}}};
    localparam logic signed [CW_W-1:0] CW_MIN = {1'b1, {(CW_W-1){1'b0}}};

    // command codes
    localparam logic [1:0] CMD_PICK = 2'd0;
    localparam logic [1:0] CMD_UP   = 2'd1;
    localparam logic [1:0] CMD_SETW = 2'd2;
    localparam logic [1:0] CMD_DOWN = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [3:0]          worker_index;
        logic [WEIGHT_W-1:0] new_weight;
    } t_in_item;

    typedef struct packed {
        logic       granted;
        logic [3:0] chosen_worker;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/core/swrr_sat_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared saturating add / subtract of a 40-bit signed value and an unsigned term.
module swrr_sat_alu (
    input  wire logic signed [swrr_pkg::CW_W-1:0]  i_a,
    input  wire logic        [swrr_pkg::TOT_W-1:0] i_b,
    input  wire logic                              i_sub,
    output logic signed      [swrr_pkg::CW_W-1:0]  o_y
);

    logic signed [swrr_pkg::CW_W:0] a_x;
    logic signed [swrr_pkg::CW_W:0] b_x;
    logic signed [swrr_pkg::CW_W:0] s;

    always_comb begin
        a_x = {i_a[swrr_pkg::CW_W-1], i_a};
        b_x = signed'((swrr_pkg::CW_W+1)'(i_b));
        s   = i_sub ? (a_x - b_x) : (a_x + b_x);
        if (s[swrr_pkg::CW_W] != s[swrr_pkg::CW_W-1]) begin
            o_y = s[swrr_pkg::CW_W] ? swrr_pkg::CW_MIN : swrr_pkg::CW_MAX;
        end else begin
            o_y = s[swrr_pkg::CW_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/smooth_weighted_round_robin_picker_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Smooth weighted round-robin picker over NUM_WORKERS workers. Every input beat
// yields exactly one output beat. Commands up / set weight / down update the
// table at the accepting edge and then wait in ST_FIN, which loads the output
// register once it is free. A pick walks the pool in ST_SCAN with one shared
// saturating adder, one worker per cycle, then in ST_WB reuses that adder to
// charge the winner the eligible total, and ST_FIN loads the output register
// once it is free. The block takes one beat at a time and takes the next one
// the cycle after the output register loads; o_in_stall is high while a beat
// is in work and while its result has not yet moved into the output register.
module smooth_weighted_round_robin_picker_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire swrr_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output swrr_pkg::t_out_item       o_out_data
);

    localparam int N     = swrr_pkg::NUM_WORKERS;
    localparam int IDX_W = swrr_pkg::IDX_W;
    localparam int CNT_W = swrr_pkg::CNT_W;
    localparam int WW    = swrr_pkg::WEIGHT_W;
    localparam int CW_W  = swrr_pkg::CW_W;
    localparam int TOT_W = swrr_pkg::TOT_W;
    localparam int ADR_W = 4 + CNT_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] r_state;

    // worker table
    logic                   r_ready  [N];
    logic [WW-1:0]          r_weight [N];
    logic signed [CW_W-1:0] r_cw     [N];

    // pick scratch
    logic [CNT_W-1:0]       r_scan;
    logic [TOT_W-1:0]       r_total;
    logic                   r_found;
    logic [IDX_W-1:0]       r_best;
    logic signed [CW_W-1:0] r_best_cw;

    // output register
    logic                   r_out_valid;
    swrr_pkg::t_out_item    r_out;
    swrr_pkg::t_out_item    r_res;

    logic                   in_fire;
    logic                   out_free;
    logic [IDX_W-1:0]       scan_idx;
    logic                   elig;
    logic signed [CW_W-1:0] alu_a;
    logic [TOT_W-1:0]       alu_b;
    logic                   alu_sub;
    logic signed [CW_W-1:0] alu_y;
    logic [ADR_W-1:0]       cmd_adr;
    logic                   cmd_ok;
    logic [IDX_W-1:0]       cmd_idx;
    logic [IDX_W+3:0]       best_x;

    assign in_fire  = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign scan_idx = r_scan[IDX_W-1:0];
    assign elig     = r_ready[scan_idx] && (r_weight[scan_idx] != '0);
    assign cmd_adr  = ADR_W'(i_in_data.worker_index);
    assign cmd_ok   = cmd_adr < ADR_W'(N);
    assign cmd_idx  = cmd_adr[IDX_W-1:0];
    assign best_x   = (IDX_W + 4)'(r_best);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // one adder serves the scan (cw + weight) and the winner charge (cw - total)
    always_comb begin
        if (r_state == ST_WB) begin
            alu_a   = r_best_cw;
            alu_b   = r_total;
            alu_sub = 1'b1;
        end else begin
            alu_a   = r_cw[scan_idx];
            alu_b   = TOT_W'(r_weight[scan_idx]);
            alu_sub = 1'b0;
        end
    end

    swrr_sat_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_y   (alu_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            r_found     <= 1'b0;
            r_total     <= '0;
            for (int k = 0; k < N; k++) begin
                r_ready[k]  <= 1'b0;
                r_weight[k] <= '0;
                r_cw[k]     <= '0;
            end
        end else begin
            // set when a result loads, cleared when the beat leaves
            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_res.granted       <= 1'b0;
                        r_res.chosen_worker <= '0;
                        r_scan              <= '0;
                        r_found             <= 1'b0;
                        r_total             <= '0;
                        unique case (i_in_data.cmd)
                            swrr_pkg::CMD_PICK: begin
                                r_state <= ST_SCAN;
                            end
                            swrr_pkg::CMD_UP: begin
                                if (cmd_ok) begin
                                    r_ready[cmd_idx]  <= 1'b1;
                                    r_weight[cmd_idx] <= (i_in_data.new_weight != '0)
                                                         ? i_in_data.new_weight : WW'(1);
                                    r_cw[cmd_idx]     <= '0;
                                end
                                r_state <= ST_FIN;
                            end
                            swrr_pkg::CMD_SETW: begin
                                if (cmd_ok) begin
                                    r_weight[cmd_idx] <= i_in_data.new_weight;
                                end
                                r_state <= ST_FIN;
                            end
                            swrr_pkg::CMD_DOWN: begin
                                if (cmd_ok) begin
                                    r_ready[cmd_idx] <= 1'b0;
                                end
                                r_state <= ST_FIN;
                            end
                            default: begin
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (elig) begin
                        r_cw[scan_idx] <= alu_y;
                        r_total        <= r_total + TOT_W'(r_weight[scan_idx]);
                        if (!r_found || (alu_y > r_best_cw)) begin
                            r_found   <= 1'b1;
                            r_best    <= scan_idx;
                            r_best_cw <= alu_y;
                        end
                    end
                    if (r_scan == CNT_W'(N - 1)) begin
                        r_state <= ST_WB;
                    end else begin
                        r_scan <= r_scan + CNT_W'(1);
                    end
                end
                ST_WB: begin
                    if (r_found) begin
                        r_cw[r_best]        <= alu_y;
                        r_res.granted       <= 1'b1;
                        r_res.chosen_worker <= best_x[3:0];
                    end
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
